@@ src/cpba_pkg.sv @@
package cpba_pkg;

	localparam int          DEPTH_DEF = 64;
	localparam logic [31:0] CAP_RESET = 32'd1048576;
	localparam int          OCC_W     = 7;

	typedef enum logic [1:0] {
		CMD_ENQ    = 2'd0,
		CMD_DEQ    = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_PREEMPT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOROOM   = 3'd3,
		ST_NOVICTIM = 3'd4,
		ST_LOST     = 3'd5,
		ST_NOTFOUND = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FREE,
		S_EVAL,
		S_PRESS,
		S_SCAN,
		S_POST,
		S_MOVE_RD,
		S_MOVE_WR,
		S_REFREE,
		S_REFIT,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [63:0]        bndl_id;
		logic [31:0]        bundle_size;
		logic signed [7:0]  bundle_priority;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               victim_valid;
		logic [63:0]        victim_id;
		logic [31:0]        found_size;
		logic signed [7:0]  found_priority;
		logic [OCC_W-1:0]   occupancy;
		logic [31:0]        used_bytes;
	} rsp_t;

	typedef struct packed {
		logic [63:0]        id;
		logic [31:0]        size;
		logic signed [7:0]  prio;
	} entry_t;

	typedef struct packed {
		logic start;
		logic victim;
		logic sample;
	} scan_ctl_t;

endpackage

@@ src/class_preemptive_buffer_admission_unit.sv @@
// Class-preemptive buffer admission table. Holds up to TABLE_DEPTH bundles
// (id, byte size, signed class) against the byte capacity in cfg_wr_data,
// which is to be written with cfg_wr_en only while the block is idle; the
// block itself does not enforce this. Enqueue admits a bundle when a slot and
// enough free bytes exist; a full table refuses it. Otherwise, when free bytes
// are under a tenth of capacity, the first stored bundle of lowest class
// strictly below the incoming one is evicted (last slot moved into the hole)
// and the bundle is admitted if it then fits. Dequeue and lookup act on the
// first slot with a matching id. One transaction is worked at a time. The
// scan for dequeue, lookup and preemptive enqueue is bound by the single read
// port of the slot memory, which it walks one entry per cycle. A finished
// result waits in an output register while the next transaction is accepted.
// The slot memory has no reset and needs no clearing pass; only slots below
// the occupancy are ever read.
module class_preemptive_buffer_admission_unit #(
	parameter int TABLE_DEPTH = cpba_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [31:0]       cfg_wr_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  cpba_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cpba_pkg::rsp_t    rsp
);
	import cpba_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// control state
	state_t            state_q, state_d;
	logic [31:0]       cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       load_q;
	logic [CNT_W-1:0]  iss_q;
	logic              smp_vld_s1;
	logic              rsp_valid_q;

	// working payload
	req_t              req_q;
	logic signed [32:0] free_q;
	logic signed [36:0] tenfree_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic [IDX_W-1:0]  idx_s1;

	// decisions
	logic              full;
	logic              fits;
	logic              pressure;
	logic              scan_rd;
	logic              scan_done;
	logic              is_enq;
	logic              out_free;
	logic [CNT_W-1:0]  cnt_last;

	// memory and scan unit hookup
	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_idx;
	entry_t            mem_wr_entry;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_idx;
	entry_t            mem_rd_entry;
	scan_ctl_t         scan_ctl;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	entry_t            hit_entry;

	logic [OCC_W+CNT_W-1:0] occ_wide;

	cpba_slot_mem #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk      (clk),
		.wr_en    (mem_wr_en),
		.wr_idx   (mem_wr_idx),
		.wr_entry (mem_wr_entry),
		.rd_en    (mem_rd_en),
		.rd_idx   (mem_rd_idx),
		.rd_entry (mem_rd_entry)
	);

	cpba_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.key_id    (req_q.bndl_id),
		.key_prio  (req_q.bundle_priority),
		.smp_idx   (idx_s1),
		.smp       (mem_rd_entry),
		.hit       (hit),
		.hit_idx   (hit_idx),
		.hit_entry (hit_entry)
	);

	assign is_enq   = (req_q.cmd == CMD_ENQ);
	assign cnt_last = count_q - CNT_W'(1);
	assign full     = (count_q >= CNT_W'(TABLE_DEPTH));
	// signed free bytes against the unsigned bundle size
	assign fits     = ($signed({free_q[32], free_q}) >= $signed({2'b00, req_q.bundle_size}));
	// 10 * free below capacity; negative free always counts
	assign pressure = ($signed(tenfree_q) < $signed({5'b00000, cap_q}));
	// scan issues one read per cycle; the sample lands in the next cycle
	assign scan_rd   = (state_q == S_SCAN) && (iss_q < count_q);
	assign scan_done = (state_q == S_SCAN) && (iss_q == count_q) && !smp_vld_s1;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_FREE;
				end
			end
			S_FREE: begin
				unique case (req_q.cmd) inside
					CMD_ENQ:                state_d = S_EVAL;
					CMD_DEQ, CMD_LOOKUP:    state_d = S_SCAN;
					default:                state_d = S_DONE;
				endcase
			end
			S_EVAL: begin
				if (full || fits) begin
					state_d = S_DONE;
				end else begin
					state_d = S_PRESS;
				end
			end
			S_PRESS: begin
				state_d = pressure ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_POST;
				end
			end
			S_POST: begin
				if (hit && (req_q.cmd != CMD_LOOKUP)) begin
					state_d = S_MOVE_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MOVE_RD: state_d = S_MOVE_WR;
			S_MOVE_WR: state_d = is_enq ? S_REFREE : S_DONE;
			S_REFREE:  state_d = S_REFIT;
			S_REFIT:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_ready       = (state_q == S_IDLE);
		mem_wr_en       = 1'b0;
		mem_wr_idx      = count_q[IDX_W-1:0];
		mem_wr_entry    = '{id: req_q.bndl_id, size: req_q.bundle_size,
		                    prio: req_q.bundle_priority};
		mem_rd_en       = scan_rd;
		mem_rd_idx      = iss_q[IDX_W-1:0];
		scan_ctl.start  = 1'b0;
		scan_ctl.victim = is_enq;
		scan_ctl.sample = smp_vld_s1;
		unique case (state_q)
			S_FREE: begin
				scan_ctl.start = (req_q.cmd == CMD_DEQ) || (req_q.cmd == CMD_LOOKUP);
			end
			S_EVAL: begin
				// append at the end of the table
				mem_wr_en = !full && fits;
			end
			S_PRESS: begin
				scan_ctl.start = pressure;
			end
			S_MOVE_RD: begin
				mem_rd_en  = 1'b1;
				mem_rd_idx = cnt_last[IDX_W-1:0];
			end
			S_MOVE_WR: begin
				// last slot fills the hole
				mem_wr_en    = 1'b1;
				mem_wr_idx   = hit_idx;
				mem_wr_entry = mem_rd_entry;
			end
			S_REFIT: begin
				mem_wr_en = fits;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			load_q      <= '0;
			iss_q       <= '0;
			smp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			smp_vld_s1 <= scan_rd;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (scan_ctl.start) begin
				iss_q <= '0;
			end else if (scan_rd) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			// append in the fit check or after preemption
			if (((state_q == S_EVAL) && !full && fits) || ((state_q == S_REFIT) && fits)) begin
				count_q <= count_q + CNT_W'(1);
				load_q  <= load_q + req_q.bundle_size;
			end else if (state_q == S_MOVE_WR) begin
				count_q <= cnt_last;
				load_q  <= load_q - hit_entry.size;
			end
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign occ_wide = {{OCC_W{1'b0}}, count_q};

	// working payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IDX_W-1:0];
		if (req_ready && req_valid) begin
			req_q <= req;
		end
		if ((state_q == S_FREE) || (state_q == S_REFREE)) begin
			free_q <= $signed({1'b0, cap_q}) - $signed({1'b0, load_q});
		end
		if (state_q == S_EVAL) begin
			tenfree_q <= ($signed({{4{free_q[32]}}, free_q}) <<< 3)
			           + ($signed({{4{free_q[32]}}, free_q}) <<< 1);
		end
		unique case (state_q)
			S_FREE: begin
				res_q <= '0;
			end
			S_EVAL: begin
				if (full) begin
					res_q.status <= ST_FULL;
				end
			end
			S_PRESS: begin
				if (!pressure) begin
					res_q.status <= ST_NOROOM;
				end
			end
			S_POST: begin
				if (!hit) begin
					res_q.status <= is_enq ? ST_NOVICTIM : ST_NOTFOUND;
				end else if (is_enq) begin
					res_q.victim_valid <= 1'b1;
					res_q.victim_id    <= hit_entry.id;
				end else begin
					res_q.found_size     <= hit_entry.size;
					res_q.found_priority <= hit_entry.prio;
				end
			end
			S_REFIT: begin
				res_q.status <= fits ? ST_PREEMPT : ST_LOST;
			end
			default: begin
			end
		endcase
		// occupancy and byte total are taken after the update
		if ((state_q == S_DONE) && out_free) begin
			rsp_q <= '{status: res_q.status, victim_valid: res_q.victim_valid,
			           victim_id: res_q.victim_id, found_size: res_q.found_size,
			           found_priority: res_q.found_priority,
			           occupancy: occ_wide[OCC_W-1:0], used_bytes: load_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ src/cpba_slot_mem.sv @@
module cpba_slot_mem #(
	parameter int DEPTH = cpba_pkg::DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  cpba_pkg::entry_t   wr_entry,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_idx,
	output cpba_pkg::entry_t   rd_entry
);
	import cpba_pkg::*;

	// one write and one registered read port
	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_idx];
		end
	end

endmodule

@@ src/cpba_scan.sv @@
module cpba_scan #(
	parameter int IDX_W = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpba_pkg::scan_ctl_t   ctl,
	input  logic [63:0]           key_id,
	input  logic signed [7:0]     key_prio,
	input  logic [IDX_W-1:0]      smp_idx,
	input  cpba_pkg::entry_t      smp,
	output logic                  hit,
	output logic [IDX_W-1:0]      hit_idx,
	output cpba_pkg::entry_t      hit_entry
);
	import cpba_pkg::*;

	logic              hit_q;
	logic signed [7:0] best_prio_q;
	logic [IDX_W-1:0]  hit_idx_q;
	entry_t            hit_entry_q;
	logic              take;

	// victim: strictly lowest class below the key, first one kept
	// id match: first equal id kept
	always_comb begin
		if (ctl.victim) begin
			take = ctl.sample && ($signed(smp.prio) < best_prio_q);
		end else begin
			take = ctl.sample && !hit_q && (smp.id == key_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.start) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			best_prio_q <= key_prio;
		end else if (take) begin
			best_prio_q <= smp.prio;
			hit_idx_q   <= smp_idx;
			hit_entry_q <= smp;
		end
	end

	assign hit       = hit_q;
	assign hit_idx   = hit_idx_q;
	assign hit_entry = hit_entry_q;

endmodule
